[hw/rtl/nfr_pkg.sv]
// nfr_pkg: shared types and constants for the nfc frame receiver
// depends on nothing; used by nfr_ctrl, nfr_datapath and nfc_frame_receiver_unit

package nfr_pkg;

   // default sizes handed to the top level
   localparam int WINDOW_DEFAULT      = 128;
   localparam int PAYLOAD_MAX_DEFAULT = 64;

   // register reset and start code bytes
   localparam logic [6:0] OUT_LIMIT_RESET = 7'd64;
   localparam logic [7:0] START_ZERO      = 8'h00;
   localparam logic [7:0] START_CODE      = 8'hFF;

   typedef enum logic [1:0] {
      STAT_OK               = 2'd0,
      STAT_INVALID_RESPONSE = 2'd1,
      STAT_CHECKSUM_ERROR   = 2'd2,
      STAT_INVALID_SIZE     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_HUNT,
      ST_LEN,
      ST_LCS,
      ST_DATA,
      ST_DCS,
      ST_DONE,
      ST_EMIT,
      ST_DRAIN_RD,
      ST_DRAIN_LD
   } state_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       start_of_read;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic [1:0] status;
      logic [6:0] payload_count;
      logic       last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       begin_read;
      logic       step;
      logic       shift_prev;
      logic       load_len;
      logic       clear_data;
      logic       take_data;
      logic       set_status;
      status_type status;
      logic       drain_clear;
      logic       drain_next;
      logic       load_single;
      logic       load_data;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_match;
      logic hunt_late;
      logic len_cs_bad;
      logic size_bad;
      logic len_zero;
      logic data_done;
      logic data_cs_bad;
      logic count_zero;
      logic drain_last;
      logic out_free;
   } flags_type;

endpackage

[hw/rtl/nfr_ctrl.sv]
// nfr_ctrl: frame parsing and result drain state machine
// depends on nfr_pkg; drives the command struct of nfr_datapath

module nfr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               start_of_read,
   output logic               req_stall,
   input  nfr_pkg::flags_type flags,
   output nfr_pkg::cmd_type   cmd
);

   nfr_pkg::state_type state_ff, state_in;
   logic               parse_state;
   logic               accept;

   assign parse_state = (state_ff == nfr_pkg::ST_HUNT) || (state_ff == nfr_pkg::ST_LEN) ||
                        (state_ff == nfr_pkg::ST_LCS)  || (state_ff == nfr_pkg::ST_DATA) ||
                        (state_ff == nfr_pkg::ST_DCS)  || (state_ff == nfr_pkg::ST_DONE);
   assign req_stall = !parse_state;
   assign accept    = req_valid && parse_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nfr_pkg::ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept && start_of_read) begin
         state_in = nfr_pkg::ST_HUNT;
      end else begin
         unique case (state_ff)
            nfr_pkg::ST_HUNT: begin
               if (accept) begin
                  if (flags.start_match) state_in = nfr_pkg::ST_LEN;
                  else if (flags.hunt_late) state_in = nfr_pkg::ST_EMIT;
               end
            end
            nfr_pkg::ST_LEN: begin
               if (accept) state_in = nfr_pkg::ST_LCS;
            end
            nfr_pkg::ST_LCS: begin
               if (accept) begin
                  if (flags.len_cs_bad || flags.size_bad) state_in = nfr_pkg::ST_EMIT;
                  else if (flags.len_zero) state_in = nfr_pkg::ST_DCS;
                  else state_in = nfr_pkg::ST_DATA;
               end
            end
            nfr_pkg::ST_DATA: begin
               if (accept && flags.data_done) state_in = nfr_pkg::ST_DCS;
            end
            nfr_pkg::ST_DCS: begin
               if (accept) begin
                  if (flags.data_cs_bad || flags.count_zero) state_in = nfr_pkg::ST_EMIT;
                  else state_in = nfr_pkg::ST_DRAIN_RD;
               end
            end
            nfr_pkg::ST_DONE: begin
               state_in = nfr_pkg::ST_DONE;
            end
            nfr_pkg::ST_EMIT: begin
               if (flags.out_free) state_in = nfr_pkg::ST_DONE;
            end
            nfr_pkg::ST_DRAIN_RD: begin
               state_in = nfr_pkg::ST_DRAIN_LD;
            end
            nfr_pkg::ST_DRAIN_LD: begin
               if (flags.out_free) begin
                  state_in = flags.drain_last ? nfr_pkg::ST_DONE : nfr_pkg::ST_DRAIN_RD;
               end
            end
            default: state_in = nfr_pkg::ST_HUNT;
         endcase
      end
   end

   // command outputs
   always_comb begin
      cmd        = '0;
      cmd.status = nfr_pkg::STAT_OK;
      if (accept && start_of_read) begin
         cmd.begin_read = 1'b1;
      end else begin
         unique case (state_ff)
            nfr_pkg::ST_HUNT: begin
               if (accept) begin
                  cmd.step       = 1'b1;
                  cmd.shift_prev = 1'b1;
                  if (!flags.start_match && flags.hunt_late) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = nfr_pkg::STAT_INVALID_RESPONSE;
                  end
               end
            end
            nfr_pkg::ST_LEN: begin
               if (accept) begin
                  cmd.step     = 1'b1;
                  cmd.load_len = 1'b1;
               end
            end
            nfr_pkg::ST_LCS: begin
               if (accept) begin
                  cmd.step = 1'b1;
                  priority if (flags.len_cs_bad) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = nfr_pkg::STAT_CHECKSUM_ERROR;
                  end else if (flags.size_bad) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = nfr_pkg::STAT_INVALID_SIZE;
                  end else begin
                     cmd.clear_data = 1'b1;
                  end
               end
            end
            nfr_pkg::ST_DATA: begin
               if (accept) begin
                  cmd.step      = 1'b1;
                  cmd.take_data = 1'b1;
               end
            end
            nfr_pkg::ST_DCS: begin
               if (accept) begin
                  cmd.step = 1'b1;
                  priority if (flags.data_cs_bad) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = nfr_pkg::STAT_CHECKSUM_ERROR;
                  end else if (flags.count_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = nfr_pkg::STAT_OK;
                  end else begin
                     cmd.drain_clear = 1'b1;
                  end
               end
            end
            nfr_pkg::ST_DONE: begin
               cmd.step = 1'b0;
            end
            nfr_pkg::ST_EMIT: begin
               cmd.load_single = flags.out_free;
            end
            nfr_pkg::ST_DRAIN_RD: begin
               cmd.step = 1'b0;
            end
            nfr_pkg::ST_DRAIN_LD: begin
               cmd.load_data  = flags.out_free;
               cmd.drain_next = flags.out_free;
            end
            default: cmd.step = 1'b0;
         endcase
      end
   end

endmodule

[hw/rtl/nfr_datapath.sv]
// nfr_datapath: frame registers, checksums, payload store and result register
// depends on nfr_pkg; commanded by nfr_ctrl

module nfr_datapath #(
   parameter int WINDOW      = nfr_pkg::WINDOW_DEFAULT,
   parameter int PAYLOAD_MAX = nfr_pkg::PAYLOAD_MAX_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  nfr_pkg::req_type   req_data,
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data,
   input  nfr_pkg::cmd_type   cmd,
   output nfr_pkg::flags_type flags,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nfr_pkg::rsp_type   rsp_data
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int AW    = $clog2(PAYLOAD_MAX);
   localparam int SZ_W  = ((IDX_W > 8) ? IDX_W : 8) + 2;
   localparam logic [IDX_W:0] LATE_IDX = (IDX_W + 1)'(WINDOW - 5);

   logic [6:0]       out_limit_ff;
   logic [IDX_W-1:0] index_ff;
   logic [7:0]       prev_one_ff, prev_two_ff;
   logic [7:0]       frame_len_ff;
   logic [7:0]       data_sum_ff;
   logic [7:0]       data_count_ff;
   logic [1:0]       status_ff;
   logic [AW-1:0]    rd_idx_ff;
   logic [7:0]       rd_data_ff;
   logic             rsp_valid_ff;
   nfr_pkg::rsp_type rsp_ff, rsp_in;
   logic [7:0]       store_mem [PAYLOAD_MAX];

   logic [IDX_W-1:0] index_in;
   logic [7:0]       rx;
   logic [6:0]       limit;
   logic [7:0]       count_n;
   logic             store_we;

   assign rx       = req_data.rx_byte;
   assign index_in = index_ff + IDX_W'(1);
   assign limit    = (out_limit_ff > 7'(PAYLOAD_MAX)) ? 7'(PAYLOAD_MAX) : out_limit_ff;
   assign count_n  = ({1'b0, limit} < frame_len_ff) ? {1'b0, limit} : frame_len_ff;
   assign store_we = cmd.take_data && (data_count_ff < {1'b0, limit});

   // status toward the controller
   always_comb begin
      flags.start_match = (prev_two_ff == nfr_pkg::START_ZERO) &&
                          (prev_one_ff == nfr_pkg::START_ZERO) && (rx == nfr_pkg::START_CODE);
      flags.hunt_late   = {1'b0, index_in} >= LATE_IDX;
      flags.len_cs_bad  = (frame_len_ff + rx) != 8'd0;
      flags.size_bad    = (SZ_W'(index_in) + SZ_W'(1) + SZ_W'(frame_len_ff)) >= SZ_W'(WINDOW);
      flags.len_zero    = frame_len_ff == 8'd0;
      flags.data_done   = ({1'b0, data_count_ff} + 9'd1) >= {1'b0, frame_len_ff};
      flags.data_cs_bad = (data_sum_ff + rx) != 8'd0;
      flags.count_zero  = count_n == 8'd0;
      flags.drain_last  = (8'(rd_idx_ff) + 8'd1) == count_n;
      flags.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_limit_ff <= nfr_pkg::OUT_LIMIT_RESET;
      end else if (csr_wr_en) begin
         out_limit_ff <= csr_wr_data;
      end
   end

   // frame tracking registers
   always_ff @(posedge clock) begin
      if (reset || cmd.begin_read) begin
         index_ff      <= '0;
         prev_one_ff   <= nfr_pkg::START_CODE;
         prev_two_ff   <= nfr_pkg::START_CODE;
         frame_len_ff  <= '0;
         data_sum_ff   <= '0;
         data_count_ff <= '0;
      end else begin
         if (cmd.step) index_ff <= index_in;
         if (cmd.shift_prev) begin
            prev_two_ff <= prev_one_ff;
            prev_one_ff <= rx;
         end
         if (cmd.load_len) frame_len_ff <= rx;
         if (cmd.clear_data) begin
            data_sum_ff   <= '0;
            data_count_ff <= '0;
         end else if (cmd.take_data) begin
            data_sum_ff   <= data_sum_ff + rx;
            data_count_ff <= data_count_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_status) status_ff <= cmd.status;
   end

   // payload store, registered read
   always_ff @(posedge clock) begin
      if (store_we) store_mem[data_count_ff[AW-1:0]] <= rx;
      rd_data_ff <= store_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.drain_clear) begin
         rd_idx_ff <= '0;
      end else if (cmd.drain_next) begin
         rd_idx_ff <= rd_idx_ff + AW'(1);
      end
   end

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_single) begin
         rsp_in.payload_byte  = 8'd0;
         rsp_in.byte_valid    = 1'b0;
         rsp_in.status        = status_ff;
         rsp_in.payload_count = 7'd0;
         rsp_in.last          = 1'b1;
      end else if (cmd.load_data) begin
         rsp_in.payload_byte  = rd_data_ff;
         rsp_in.byte_valid    = 1'b1;
         rsp_in.status        = nfr_pkg::STAT_OK;
         rsp_in.payload_count = flags.drain_last ? count_n[6:0] : 7'd0;
         rsp_in.last          = flags.drain_last;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_single || cmd.load_data) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/nfc_frame_receiver_unit.sv]
// nfc_frame_receiver_unit: top level of the information frame receiver
// depends on nfr_pkg, nfr_ctrl and nfr_datapath
//
//   port group   dir   handshake          payload
//   req_*        in    req_valid/stall    nfr_pkg::req_type (rx_byte, start_of_read)
//   rsp_*        out   rsp_valid/stall    nfr_pkg::rsp_type (byte, valid, status, count, last)
//   csr_*        in    csr_wr_en          out_limit, 7 bits
//
// while a frame is parsed one byte is taken per cycle
// a good frame drains its n buffered bytes one by one (store read, then
//   result register load), with req_stall high until the last transfer is loaded
// an error, an empty frame or a zero out_limit loads one bare result, input again held meanwhile
// reset is synchronous; the payload store needs no clearing pass
// the result register frees as soon as rsp_stall drops, so a waiting result
//   does not block bytes of the window that follow the verdict

module nfc_frame_receiver_unit #(
   parameter int WINDOW      = nfr_pkg::WINDOW_DEFAULT,
   parameter int PAYLOAD_MAX = nfr_pkg::PAYLOAD_MAX_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   // byte input channel
   input  logic             req_valid,
   output logic             req_stall,
   input  nfr_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nfr_pkg::rsp_type rsp_data,
   // out_limit register
   input  logic             csr_wr_en,
   input  logic [6:0]       csr_wr_data
);

   // command and status between controller and datapath
   nfr_pkg::cmd_type   cmd;
   nfr_pkg::flags_type flags;

   // state machine: hunt, length, length checksum, data, data checksum, emit, drain, done
   nfr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .start_of_read (req_data.start_of_read),
      .req_stall     (req_stall),
      .flags         (flags),
      .cmd           (cmd)
   );

   // index, checksums, payload store and result register
   nfr_datapath #(
      .WINDOW      (WINDOW),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .flags       (flags),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

[bench/tb_nfc_frame_receiver_unit.sv]
`timescale 1ns / 1ps
// tb_nfc_frame_receiver_unit: self-checking bench for the information frame receiver
// sends read windows byte by byte, mirrors the frame parser and checks every result
// depends on nfr_pkg and nfc_frame_receiver_unit

module tb_nfc_frame_receiver_unit;

   localparam int WINDOW        = nfr_pkg::WINDOW_DEFAULT;
   localparam int PAYLOAD_MAX   = nfr_pkg::PAYLOAD_MAX_DEFAULT;
   localparam int HUNT_LAST     = WINDOW - 5;   // last index that may still hunt
   localparam int TOTAL_ITEMS   = 470;          // input transfers over the whole run
   localparam int QUIET_TAIL    = 70;           // items at the end sent with no idling
   localparam int SETTLE_CYCLES = 12;           // settle time once every owed result is taken
   localparam int STUCK_LIMIT   = 1000;

   // parse phases of the mirrored frame parser
   typedef enum logic [2:0] {
      PARSE_HUNT,
      PARSE_LEN,
      PARSE_LCS,
      PARSE_DATA,
      PARSE_DCS
   } parse_phase_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   nfr_pkg::req_type req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   nfr_pkg::rsp_type rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [6:0]       csr_wr_data = '0;

   // mirrored parser state and register
   logic [6:0]      out_limit_reg;
   int unsigned     win_idx;
   parse_phase_type phase;
   logic [7:0]      prev_one;
   logic [7:0]      prev_two;
   logic [7:0]      frame_len;
   logic [7:0]      data_sum;
   int unsigned     data_cnt;
   logic [7:0]      payload_mem [PAYLOAD_MAX];
   bit              verdict_done;

   nfr_pkg::rsp_type frame_results_q [$];   // results still owed by the block, oldest first
   logic [7:0]       window_q [$];          // bytes of the window being built
   bit               idle_on;
   int unsigned      sent_items;            // input transfers so far
   int unsigned      mismatches;
   int unsigned      quiet_cycles;

   nfc_frame_receiver_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // frame parser mirror
   // ---------------------------------------------------------------------------

   // state at the status byte; also the state right after reset
   function automatic void open_window();
      win_idx      = 0;
      phase        = PARSE_HUNT;
      prev_one     = 8'hFF;
      prev_two     = 8'hFF;
      frame_len    = 8'h00;
      data_sum     = 8'h00;
      data_cnt     = 0;
      verdict_done = 1'b0;
   endfunction

   function automatic void push_result(input logic [7:0] b, input logic v,
                                       input nfr_pkg::status_type s, input logic [6:0] n,
                                       input logic l);
      nfr_pkg::rsp_type r;
      r.payload_byte  = b;
      r.byte_valid    = v;
      r.status        = s;
      r.payload_count = n;
      r.last          = l;
      frame_results_q.push_back(r);
   endfunction

   // error verdicts are one bare result with last set
   function automatic void give_error(input nfr_pkg::status_type s);
      verdict_done = 1'b1;
      push_result(8'h00, 1'b0, s, 7'd0, 1'b1);
   endfunction

   // advances the parser by one window byte; returns 0 if the byte is ignored
   function automatic bit parse_window_byte(input nfr_pkg::req_type it);
      logic [7:0]  b;
      logic [7:0]  sum8;
      int unsigned lim;
      int unsigned n;
      int unsigned k;
      b   = it.rx_byte;
      lim = (out_limit_reg > PAYLOAD_MAX) ? PAYLOAD_MAX : out_limit_reg;
      if (it.start_of_read) begin
         // a new read drops whatever frame was in progress
         open_window();
         return 1'b1;
      end
      if (verdict_done) return 1'b0;
      if (win_idx < 16'hFFFF) win_idx++;
      case (phase)
         PARSE_HUNT: begin
            if (prev_two == nfr_pkg::START_ZERO && prev_one == nfr_pkg::START_ZERO &&
                b == nfr_pkg::START_CODE) begin
               phase = PARSE_LEN;
            end else if (win_idx >= HUNT_LAST) begin
               give_error(nfr_pkg::STAT_INVALID_RESPONSE);
               return 1'b1;
            end
            prev_two = prev_one;
            prev_one = b;
         end
         PARSE_LEN: begin
            frame_len = b;
            phase     = PARSE_LCS;
         end
         PARSE_LCS: begin
            // length checksum is judged before the window fit
            sum8 = frame_len + b;
            if (sum8 != 8'h00) begin
               give_error(nfr_pkg::STAT_CHECKSUM_ERROR);
            end else if (win_idx + 1 + frame_len >= WINDOW) begin
               give_error(nfr_pkg::STAT_INVALID_SIZE);
            end else begin
               data_sum = 8'h00;
               data_cnt = 0;
               phase    = (frame_len == 8'h00) ? PARSE_DCS : PARSE_DATA;
            end
         end
         PARSE_DATA: begin
            // every data byte is summed, only the first lim are kept
            data_sum = data_sum + b;
            if (data_cnt < lim) payload_mem[data_cnt] = b;
            data_cnt++;
            if (data_cnt >= frame_len) phase = PARSE_DCS;
         end
         PARSE_DCS: begin
            sum8 = data_sum + b;
            if (sum8 != 8'h00) begin
               give_error(nfr_pkg::STAT_CHECKSUM_ERROR);
            end else begin
               verdict_done = 1'b1;
               n = (frame_len < lim) ? frame_len : lim;
               if (n == 0) begin
                  // empty frame or nothing allowed out: one bare ok result
                  push_result(8'h00, 1'b0, nfr_pkg::STAT_OK, 7'd0, 1'b1);
               end else begin
                  for (k = 0; k < n; k++) begin
                     push_result(payload_mem[k], 1'b1, nfr_pkg::STAT_OK,
                                 (k + 1 == n) ? 7'(n) : 7'd0, k + 1 == n);
                  end
               end
            end
         end
         default: verdict_done = 1'b1;
      endcase
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // result checking and watchdog, sampled at the falling edge so that values
   // are settled; a transfer seen here completes at the next rising edge
   // ---------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void compare_result(input nfr_pkg::rsp_type got);
      nfr_pkg::rsp_type want;
      if (frame_results_q.size() == 0) begin
         $error("result with nothing owed: byte %0h last %0b", got.payload_byte, got.last);
         mismatches++;
      end else begin
         want = frame_results_q.pop_front();
         check_field("payload_byte", want.payload_byte, got.payload_byte);
         check_field("byte_valid", want.byte_valid, got.byte_valid);
         check_field("status", want.status, got.status);
         check_field("payload_count", want.payload_count, got.payload_count);
         check_field("last", want.last, got.last);
      end
   endfunction

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) compare_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         // nothing moved for far too long: the block is hung
         if (quiet_cycles >= STUCK_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // receiver side: random stall bursts while idling is on
   always begin
      @(posedge clock);
      if (!reset && idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 14)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // one byte transfer on the input channel, with an optional gap before it
   task automatic send_item(input logic [7:0] b, input logic sor);
      nfr_pkg::req_type it;
      it.rx_byte       = b;
      it.start_of_read = sor;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      void'(parse_window_byte(it));
      sent_items++;
   endtask

   // sender holds off until every owed result has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // out_limit is only written with the block idle and a verdict given
   task automatic write_limit(input logic [6:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      out_limit_reg = value;
   endtask

   // noise bytes; clean noise never holds a start code byte
   function automatic void put_noise(input int n, input bit clean);
      int sel;
      repeat (n) begin
         sel = $urandom_range(0, 5);
         if (clean) window_q.push_back(8'($urandom_range(1, 254)));
         else if (sel == 0) window_q.push_back(nfr_pkg::START_ZERO);
         else if (sel == 1) window_q.push_back(nfr_pkg::START_CODE);
         else window_q.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // start code, length, length checksum, nbytes random data, data checksum;
   // a nonzero lcs_err or dcs_err spoils that checksum
   function automatic void put_frame(input int len, input int nbytes,
                                     input logic [7:0] lcs_err, input logic [7:0] dcs_err);
      logic [7:0] len8;
      logic [7:0] sum;
      logic [7:0] d;
      len8 = len[7:0];
      sum  = 8'h00;
      window_q.push_back(nfr_pkg::START_ZERO);
      window_q.push_back(nfr_pkg::START_ZERO);
      window_q.push_back(nfr_pkg::START_CODE);
      window_q.push_back(len8);
      window_q.push_back(8'h00 - len8 + lcs_err);
      repeat (nbytes) begin
         d   = 8'($urandom_range(0, 255));
         sum = sum + d;
         window_q.push_back(d);
      end
      window_q.push_back(8'h00 - sum + dcs_err);
   endfunction

   // optional status byte, then the built window
   task automatic send_window(input bit with_status);
      if (with_status) send_item(8'($urandom_range(0, 255)), 1'b1);
      foreach (window_q[k]) send_item(window_q[k], 1'b0);
      window_q.delete();
   endtask

   function automatic logic [6:0] pick_limit();
      case ($urandom_range(0, 5))
         0:       return 7'd0;
         1:       return 7'd1;
         2:       return 7'd64;
         3:       return 7'd127;
         4:       return 7'($urandom_range(1, 8));
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // first byte after reset counts as index 1; a second frame after the
   // verdict is ignored
   task automatic test_read_without_status();
      put_frame(3, 3, 8'h00, 8'h00);
      put_frame(2, 2, 8'h00, 8'h00);
      send_window(1'b0);
   endtask

   // empty frame, then a one byte frame behind a short preamble
   task automatic test_short_frames();
      put_frame(0, 0, 8'h00, 8'h00);
      send_window(1'b1);
      put_noise(2, 1'b0);
      put_frame(1, 1, 8'h00, 8'h00);
      put_noise(3, 1'b0);
      send_window(1'b1);
   endtask

   // bad length checksum, bad length checksum on an oversize length, bad data checksum
   task automatic test_checksum_errors();
      put_frame(4, 4, 8'h01, 8'h00);
      send_window(1'b1);
      put_frame(255, 0, 8'h80, 8'h00);
      send_window(1'b1);
      put_frame(5, 5, 8'h00, 8'h01);
      send_window(1'b1);
   endtask

   // data checksum index past the window end, and exactly at it
   task automatic test_frame_size();
      put_frame(255, 0, 8'h00, 8'h00);
      send_window(1'b1);
      put_frame(WINDOW - 6, 0, 8'h00, 8'h00);
      send_window(1'b1);
   endtask

   // start code one byte too late
   task automatic test_late_start_code();
      put_noise(HUNT_LAST - 2, 1'b1);
      put_frame(0, 0, 8'h00, 8'h00);
      send_window(1'b1);
   endtask

   // new read in the middle of the data drops the frame silently
   task automatic test_read_restart();
      put_frame(6, 6, 8'h00, 8'h00);
      while (window_q.size() > 7) void'(window_q.pop_back());
      send_window(1'b1);
      put_frame(2, 2, 8'h00, 8'h00);
      send_window(1'b1);
   endtask

   // out_limit of zero, one, a truncating value, above the store size, then reset value
   task automatic test_out_limit();
      write_limit(7'd0);
      put_frame(4, 4, 8'h00, 8'h00);
      send_window(1'b1);
      write_limit(7'd1);
      put_frame(5, 5, 8'h00, 8'h00);
      send_window(1'b1);
      write_limit(7'd3);
      put_frame(10, 10, 8'h00, 8'h00);
      send_window(1'b1);
      write_limit(7'd127);
      put_frame(70, 70, 8'h00, 8'h00);
      send_window(1'b1);
      write_limit(nfr_pkg::OUT_LIMIT_RESET);
   endtask

   // mostly well-formed frames with random content, plus broken and noisy windows
   task automatic test_random_windows();
      int unsigned kind;
      int unsigned pre;
      int unsigned room;
      int unsigned len;
      int unsigned cut;
      while (sent_items < TOTAL_ITEMS) begin
         // idling comes and goes per window, and stops for the tail
         if (sent_items < TOTAL_ITEMS - QUIET_TAIL)
            idle_on = ($urandom_range(0, 3) != 0);
         else
            idle_on = 1'b0;
         if (verdict_done && $urandom_range(0, 5) == 0) write_limit(pick_limit());
         else if ($urandom_range(0, 9) == 0) wait_drained();
         kind = $urandom_range(0, 99);
         pre  = $urandom_range(0, 8);
         room = WINDOW - 7 - pre;   // longest frame whose data checksum still fits
         len  = ($urandom_range(0, 11) == 0) ? $urandom_range(13, room) : $urandom_range(0, 12);
         put_noise(pre, 1'b0);
         if (kind < 64) begin
            put_frame(len, len, 8'h00, 8'h00);
         end else if (kind < 72) begin
            put_frame(len, len, 8'($urandom_range(1, 255)), 8'h00);
         end else if (kind < 80) begin
            put_frame(len, len, 8'h00, 8'($urandom_range(1, 255)));
         end else if (kind < 87) begin
            put_frame($urandom_range(room + 1, 255), 1, 8'h00, 8'h00);
         end else if (kind < 94) begin
            // frame cut short; the next read starts over it
            put_frame(len, len, 8'h00, 8'h00);
            cut = $urandom_range(pre + 1, window_q.size() - 1);
            while (window_q.size() > cut) void'(window_q.pop_back());
         end else if (kind < 98) begin
            // start code around the last allowed index
            window_q.delete();
            len = $urandom_range(0, 2);
            put_noise($urandom_range(HUNT_LAST - 6, HUNT_LAST - 2), 1'b1);
            put_frame(len, len, 8'h00, 8'h00);
         end else begin
            // no start code at all
            window_q.delete();
            put_noise(HUNT_LAST + 1, 1'b1);
         end
         // bytes after the verdict are ignored
         if (kind < 87 || kind >= 94) put_noise($urandom_range(0, 3), 1'b0);
         send_window($urandom_range(0, 15) != 0);
      end
      idle_on = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------

   initial begin
      idle_on       = 1'b1;
      sent_items    = 0;
      mismatches    = 0;
      quiet_cycles  = 0;
      out_limit_reg = nfr_pkg::OUT_LIMIT_RESET;
      open_window();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_read_without_status();
      test_short_frames();
      test_checksum_errors();
      test_frame_size();
      test_late_start_code();
      test_read_restart();
      test_out_limit();
      test_random_windows();

      wait_drained();
      if (mismatches == 0 && frame_results_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
